/* sv/tape_byte_pulse_encoder_macros.svh */
// ----------------------------------------------------------------------------
// Tape byte pulse encoder: assertion macros
// Shared helpers for the concurrent checks of the encoder.
// ----------------------------------------------------------------------------
`ifndef TAPE_BYTE_PULSE_ENCODER_MACROS_SVH
`define TAPE_BYTE_PULSE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TBPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TBPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tbpe_pkg.sv */
// ----------------------------------------------------------------------------
// tbpe_pkg
// Types and constants shared by the tape byte pulse encoder modules.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h16;
  localparam logic [7:0] MARK_BYTE    = 8'h24;
  localparam logic [3:0] FRAME_BITS   = 4'd13;  // start, 8 data, parity, 3 stop
  localparam logic [3:0] PARITY_POS   = 4'd4;
  localparam logic [7:0] HEADER_LEN   = 8'd9;
  localparam logic [7:0] GAP_PULSES   = 8'd100;
  localparam logic [7:0] PAUSE_PULSES = 8'd255;

  // header countdown positions carrying the start/end words
  localparam logic [7:0] HDR_END_HI   = 8'd5;
  localparam logic [7:0] HDR_END_LO   = 8'd4;
  localparam logic [7:0] HDR_START_HI = 8'd3;
  localparam logic [7:0] HDR_START_LO = 8'd2;

  typedef enum logic [2:0] {
    REG_ZERO_LOW       = 3'd0,
    REG_ZERO_HIGH      = 3'd1,
    REG_ONE            = 3'd2,
    REG_TURBO_ZERO_LOW = 3'd3,
    REG_TURBO_ZERO_HI  = 3'd4,
    REG_TURBO_ONE      = 3'd5,
    REG_USE_TURBO      = 3'd6
  } cfg_reg_t;

  typedef enum logic [6:0] {
    PH_SYNC1  = 7'b0000001,
    PH_SYNC2  = 7'b0000010,
    PH_HEADER = 7'b0000100,
    PH_NAME   = 7'b0001000,
    PH_GAP    = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_PAUSE  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [15:0] zero_low_len;
    logic [15:0] zero_high_len;
    logic [15:0] one_len;
    logic [15:0] turbo_zero_low_len;
    logic [15:0] turbo_zero_high_len;
    logic [15:0] turbo_one_len;
    logic        use_turbo;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  phase_count;
    logic [3:0]  bit_position;
    logic        half_pulse;
    logic [7:0]  shift_byte;
    logic        parity_acc;
    logic        last_byte_flag;
    logic [15:0] bytes_left;
    logic        done_flag;
  } state_t;

  typedef struct packed {
    logic [15:0] pulse_length;
    logic        pulse_valid;
    logic        byte_taken;
    logic        finished;
  } result_t;

endpackage

/* sv/tape_byte_pulse_encoder.sv */
// ----------------------------------------------------------------------------
// tape_byte_pulse_encoder
// Turns a stream of tape file bytes into pulse lengths, at most one pulse per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one beat per tick. tdata = file byte, tuser = byte available.
//    A tick with tuser low means end of file; the block may stall (no pulse).
//  - Master stream: exactly one beat per slave beat, in order. tdata = pulse
//    length (0 when no pulse), tuser = {finished, byte taken, pulse valid}.
//    The source advances its file pointer only on beats with byte taken set.
//  - Config channel: cfg_index picks the register (0..6), cfg_data the value.
//    Always ready; write only while the block holds no beat in flight.
//  - Pipeline: a slave beat taken into the input register moves on into the
//    result register and is offered on the master side from there. Throughput
//    is one beat per cycle while m_tready is high, set by the combinational
//    state update between the two registers (input, then result).
//  - Stall: when m_tready is low the result register holds, the input register
//    fills, and s_tready drops only once both are full.
//  - Reset (rst, synchronous): clears both stages, the config registers and
//    the sequencer, which starts in sync reading with a pad count of 255.
// ----------------------------------------------------------------------------
module tape_byte_pulse_encoder (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] file_byte
  input  logic        s_tuser,   // [0] byte_available
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] pulse_length
  output logic [2:0]  m_tuser,   // [0] pulse_valid, [1] byte_taken, [2] finished
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tbpe_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t res;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_avail;

  logic advance;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_avail <= s_tuser;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_LOW:       cfg.zero_low_len        <= cfg_data;
        REG_ZERO_HIGH:      cfg.zero_high_len       <= cfg_data;
        REG_ONE:            cfg.one_len             <= cfg_data;
        REG_TURBO_ZERO_LOW: cfg.turbo_zero_low_len  <= cfg_data;
        REG_TURBO_ZERO_HI:  cfg.turbo_zero_high_len <= cfg_data;
        REG_TURBO_ONE:      cfg.turbo_one_len       <= cfg_data;
        REG_USE_TURBO:      cfg.use_turbo           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbpe_step u_step (
    .cfg            (cfg),
    .st             (st),
    .file_byte      (in_byte),
    .byte_available (in_avail),
    .st_next        (st_next),
    .res            (res)
  );

  // sequencer state moves only when a beat passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_SYNC1;
      st.phase_count    <= PAUSE_PULSES;
      st.bit_position   <= 4'd0;
      st.half_pulse     <= 1'b0;
      st.shift_byte     <= 8'd0;
      st.parity_acc     <= 1'b0;
      st.last_byte_flag <= 1'b0;
      st.bytes_left     <= 16'd0;
      st.done_flag      <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= res.pulse_length;
      m_tuser <= {res.finished, res.byte_taken, res.pulse_valid};
    end
  end

`include "tape_byte_pulse_encoder_macros.svh"

  `TBPE_ASSERT_NEXT(a_done_sticky, st.done_flag, st.done_flag, "finished state left")
  `TBPE_ASSERT_NOW(a_half_in_bit, st.half_pulse, st.bit_position != 4'd0, "half pulse idle")
  `TBPE_ASSERT_NOW(a_no_len_idle, m_tvalid && !m_tuser[0], m_tdata == 16'd0, "length without pulse")
  `TBPE_ASSERT_NOW(a_end_no_take, m_tvalid && m_tuser[2], !m_tuser[1], "byte taken while finished")

endmodule

/* sv/tbpe_step.sv */
// ----------------------------------------------------------------------------
// tbpe_step
// Next-state and pulse logic for one tick of the encoder.
// ----------------------------------------------------------------------------
module tbpe_step (
  input  tbpe_pkg::cfg_t    cfg,
  input  tbpe_pkg::state_t  st,
  input  logic [7:0]        file_byte,
  input  logic              byte_available,
  output tbpe_pkg::state_t  st_next,
  output tbpe_pkg::result_t res
);
  import tbpe_pkg::*;

  function automatic state_t load_byte(state_t s, logic [7:0] v);
    state_t r;
    r = s;
    r.shift_byte     = v;
    r.bit_position   = FRAME_BITS;
    r.parity_acc     = 1'b0;
    r.last_byte_flag = 1'b0;
    return r;
  endfunction

  // after the sync run: pad with sync bytes, then the marker byte
  function automatic state_t pad_or_mark(state_t s);
    state_t r;
    r = s;
    if (s.phase_count != 8'd0) begin
      r = load_byte(s, SYNC_BYTE);
      r.phase_count = s.phase_count - 8'd1;
    end else begin
      r = load_byte(s, MARK_BYTE);
      r.phase_count = HEADER_LEN;
      r.phase = PH_HEADER;
    end
    return r;
  endfunction

  logic        cur_bit;
  logic [3:0]  bp_dec;
  logic [15:0] bits_len;
  logic [15:0] left_dec;

  always_comb begin
    if (st.bit_position == FRAME_BITS)      cur_bit = 1'b0;
    else if (st.bit_position == PARITY_POS) cur_bit = ~st.parity_acc;
    else if (st.bit_position < PARITY_POS)  cur_bit = 1'b1;
    else                                    cur_bit = st.shift_byte[0];
  end

  assign bp_dec   = st.bit_position - 4'd1;
  assign left_dec = st.bytes_left - 16'd1;

  always_comb begin
    if (cur_bit)
      bits_len = cfg.use_turbo ? cfg.turbo_one_len : cfg.one_len;
    else if (!st.half_pulse)
      bits_len = cfg.use_turbo ? cfg.turbo_zero_low_len : cfg.zero_low_len;
    else
      bits_len = cfg.use_turbo ? cfg.turbo_zero_high_len : cfg.zero_high_len;
  end

  always_comb begin
    st_next = st;
    res     = '0;
    if (st.done_flag) begin
      res.finished = 1'b1;
    end else if (st.bit_position != 4'd0) begin
      res.pulse_length = bits_len;
      res.pulse_valid  = 1'b1;
      if (!st.half_pulse) begin
        st_next.half_pulse = 1'b1;
      end else begin
        st_next.half_pulse = 1'b0;
        if (st.bit_position > PARITY_POS && st.bit_position < FRAME_BITS) begin
          st_next.parity_acc = st.parity_acc ^ cur_bit;
          st_next.shift_byte = {1'b0, st.shift_byte[7:1]};
        end
        st_next.bit_position = bp_dec;
      end
      // last stop bit of the last data byte closes the block
      if (st_next.bit_position == 4'd0 && st.last_byte_flag) begin
        st_next.phase_count = PAUSE_PULSES;
        if (byte_available) begin
          st_next.phase = PH_PAUSE;
        end else begin
          st_next.done_flag = 1'b1;
          res.finished = 1'b1;
        end
      end
    end else begin
      unique case (st.phase)
        PH_SYNC2: begin
          st_next = pad_or_mark(st);
        end
        PH_HEADER: begin
          if (st.phase_count == 8'd0) begin
            st_next.phase = PH_NAME;
            if (byte_available) begin
              res.byte_taken = 1'b1;
              st_next = load_byte(st_next, file_byte);
              if (file_byte == 8'd0) begin
                st_next.phase_count = GAP_PULSES;
                st_next.phase = PH_GAP;
              end
            end
          end else if (byte_available) begin
            res.byte_taken = 1'b1;
            st_next = load_byte(st, file_byte);
            if (st.phase_count == HDR_END_HI)
              st_next.bytes_left = {file_byte, 8'h00};
            else if (st.phase_count == HDR_END_LO)
              st_next.bytes_left = st.bytes_left + {8'h00, file_byte} + 16'd1;
            else if (st.phase_count == HDR_START_HI)
              st_next.bytes_left = st.bytes_left - {file_byte, 8'h00};
            else if (st.phase_count == HDR_START_LO)
              st_next.bytes_left = st.bytes_left - {8'h00, file_byte};
            st_next.phase_count = st.phase_count - 8'd1;
          end
        end
        PH_NAME: begin
          if (byte_available) begin
            res.byte_taken = 1'b1;
            st_next = load_byte(st, file_byte);
            if (file_byte == 8'd0) begin
              st_next.phase_count = GAP_PULSES;
              st_next.phase = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          if (st.phase_count != 8'd0) begin
            res.pulse_length = cfg.one_len;
            res.pulse_valid  = 1'b1;
            st_next.phase_count = st.phase_count - 8'd1;
          end else begin
            st_next.phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (byte_available) begin
            res.byte_taken = 1'b1;
            st_next.shift_byte   = file_byte;
            st_next.bytes_left   = left_dec;
            st_next.parity_acc   = 1'b0;
            if (left_dec == 16'd0) st_next.last_byte_flag = 1'b1;
            st_next.bit_position = FRAME_BITS;
            st_next.half_pulse   = 1'b0;
          end else begin
            st_next.phase_count = PAUSE_PULSES;
            st_next.done_flag   = 1'b1;
            res.finished        = 1'b1;
          end
        end
        PH_PAUSE: begin
          if (st.phase_count != 8'd0) begin
            res.pulse_length = cfg.one_len;
            res.pulse_valid  = 1'b1;
            st_next.phase_count = st.phase_count - 8'd1;
          end else begin
            st_next.phase_count = GAP_PULSES;
            st_next.phase = PH_SYNC1;
          end
        end
        default: begin
          // sync reading (also any code outside the phase set)
          if (byte_available) begin
            res.byte_taken = 1'b1;
            st_next = load_byte(st, file_byte);
            if (file_byte == SYNC_BYTE) begin
              st_next.phase_count = st.phase_count - 8'd1;
            end else begin
              st_next.phase = PH_SYNC2;
              st_next = pad_or_mark(st_next);
            end
          end
        end
      endcase
    end
  end

endmodule
